// ----- rtl/tcce_pkg.sv -----
// Shared types, field widths and character codes for the text console engine.
// No dependencies; every other file in rtl/ imports this package.
package tcce_pkg;

   // Screen geometry defaults handed to the top level parameters
   localparam int DEF_SCREEN_ROWS = 25;
   localparam int DEF_SCREEN_COLS = 80;

   // Transaction field widths
   localparam int CHAR_W       = 8;
   localparam int ATTR_W       = 8;
   localparam int IDX_W        = 11;
   localparam int ROW_OUT_W    = 5;
   localparam int COL_OUT_W    = 7;
   localparam int POS_OUT_W    = 11;
   localparam int CELL_W       = CHAR_W + ATTR_W;
   localparam int SCROLL_CNT_W = 3;

   // Command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Character codes
   localparam logic [CHAR_W-1:0] CH_BS        = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF        = 8'd10;
   localparam logic [CHAR_W-1:0] CH_VT        = 8'd11;
   localparam logic [CHAR_W-1:0] CH_FF        = 8'd12;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
   localparam logic [CHAR_W-1:0] CH_NAK       = 8'h15;
   localparam logic [CHAR_W-1:0] CH_LAST_CTRL = 8'd31;
   localparam logic [CHAR_W-1:0] CH_DEL       = 8'd127;
   localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_DEFAULT_ATTR = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_DRAIN,
      ST_DONE
   } tcce_state_type;

   typedef enum logic [1:0] {
      SW_INIT,
      SW_CLEAR,
      SW_SCROLL
   } tcce_sweep_type;

   // Cell store actions requested by one put transaction
   typedef struct packed {
      logic                    cell_we;
      logic                    clear;
      logic [SCROLL_CNT_W-1:0] scroll_cnt;
   } tcce_act_type;

endpackage

// ----- rtl/tcce_req_if.sv -----
// Request channel: valid/ready handshake carrying one put or read transaction.
// Depends on tcce_pkg for field widths.
interface tcce_req_if import tcce_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [CHAR_W-1:0] char_code;
   logic [ATTR_W-1:0] cell_attr;
   logic [IDX_W-1:0]  cell_index;

   modport source (output valid, cmd, char_code, cell_attr, cell_index, input ready);
   modport sink   (input valid, cmd, char_code, cell_attr, cell_index, output ready);
endinterface

// ----- rtl/tcce_rsp_if.sv -----
// Response channel: valid/ready handshake carrying cursor and read-back cell.
// Depends on tcce_pkg for field widths.
interface tcce_rsp_if import tcce_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ROW_OUT_W-1:0] cursor_row;
   logic [COL_OUT_W-1:0] cursor_col;
   logic [POS_OUT_W-1:0] cursor_pos;
   logic [CHAR_W-1:0]    read_char;
   logic [ATTR_W-1:0]    read_attr;

   modport source (output valid, cursor_row, cursor_col, cursor_pos, read_char, read_attr,
                   input ready);
   modport sink   (input valid, cursor_row, cursor_col, cursor_pos, read_char, read_attr,
                   output ready);
endinterface

// ----- rtl/text_console_character_engine.sv -----
// Text console engine top level: cell store, sweep sequencer, register port.
// Depends on tcce_pkg, tcce_req_if, tcce_rsp_if and tcce_cursor.
//
// Usage
//   req_if carries one transaction at a time: cmd put shows a character or
//   acts on a control code at the cursor, cmd read returns one cell by its
//   linear index. rsp_if returns exactly one transaction per request with
//   the cursor after the request and, for reads, the cell contents.
//   default_attr sits at byte address 0 of the csr_ port; write it only
//   while no request is outstanding.
// Sequencing
//   A plain put or a read passes through accept, execute (at most one cell
//   store access) and hand-off to the response register. Each scrolled line
//   adds a full pass over the store, with up to four passes for a vertical
//   tab; form feed adds one pass. The store's one write port limits a pass
//   to one cell per cycle.
// Reset
//   The store is filled with blank cells in attribute 0x07 by one pass over
//   the store; req_if.ready stays low meanwhile.
// Back-pressure
//   The next request is taken while a response waits in the output
//   register; its result is held back until the receiver takes the first.
module text_console_character_engine import tcce_pkg::*; #(
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int SCREEN_COLS = DEF_SCREEN_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   tcce_req_if.sink              req_if,
   tcce_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CELL_COUNT = SCREEN_ROWS * SCREEN_COLS;
   localparam int RW         = $clog2(SCREEN_ROWS);
   localparam int CW         = $clog2(SCREEN_COLS);
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CMP_W      = AW + IDX_W;
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'(CELL_COUNT - SCREEN_COLS);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   tcce_state_type          state_ff, state_in;
   tcce_sweep_type          kind_ff, kind_in;
   logic [AW-1:0]           cnt_ff, cnt_in;
   logic [SCROLL_CNT_W-1:0] scroll_left_ff, scroll_left_in;
   logic [RW-1:0]           cur_row_ff, cur_row_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [ATTR_W-1:0]       default_attr_ff, default_attr_in;
   logic                    wpend_ff, wpend_in;
   logic [AW-1:0]           waddr_ff, waddr_in;
   logic                    wblank_ff, wblank_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Captured request (payload, no reset)
   logic                    item_cmd_ff;
   logic [CHAR_W-1:0]       item_char_ff;
   logic [ATTR_W-1:0]       item_attr_ff;
   logic [IDX_W-1:0]        item_idx_ff;

   // Response payload (no reset)
   logic [ROW_OUT_W-1:0]    rsp_row_ff;
   logic [COL_OUT_W-1:0]    rsp_col_ff;
   logic [POS_OUT_W-1:0]    rsp_pos_ff;
   logic [CHAR_W-1:0]       rsp_char_ff;
   logic [ATTR_W-1:0]       rsp_attr_ff;

   // Cell store: character in the low byte, attribute in the high byte
   logic [CELL_W-1:0]       cell_mem [CELL_COUNT];
   logic [CELL_W-1:0]       rd_data_ff;

   // ------------------------------------------------------------------
   // Combinational signals
   // ------------------------------------------------------------------
   tcce_act_type            act;
   logic [RW-1:0]           step_wr_row;
   logic [CW-1:0]           step_wr_col;
   logic [CHAR_W-1:0]       step_wr_char;
   logic [RW-1:0]           step_row;
   logic [CW-1:0]           step_col;
   logic [AW-1:0]           put_addr;
   logic [AW-1:0]           sweep_raddr;
   logic                    sweep_last_row;
   logic                    idx_in_range;
   logic                    put_we;
   logic                    req_ready;
   logic                    rsp_load;
   logic                    csr_write;
   logic [ATTR_W-1:0]       fill_attr;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   logic [CELL_W-1:0]       mem_wdata;
   logic                    mem_re;
   logic [AW-1:0]           mem_raddr;

   // ------------------------------------------------------------------
   // Put decoder
   // ------------------------------------------------------------------
   tcce_cursor #(
      .SCREEN_ROWS (SCREEN_ROWS),
      .SCREEN_COLS (SCREEN_COLS),
      .RW          (RW),
      .CW          (CW)
   ) u_cursor (
      .cur_row   (cur_row_ff),
      .cur_col   (cur_col_ff),
      .char_code (item_char_ff),
      .act       (act),
      .wr_row    (step_wr_row),
      .wr_col    (step_wr_col),
      .wr_char   (step_wr_char),
      .next_row  (step_row),
      .next_col  (step_col)
   );

   assign put_addr = AW'(step_wr_row) * AW'(SCREEN_COLS) + AW'(step_wr_col);
   assign put_we   = (state_ff == ST_EXEC) && (item_cmd_ff == CMD_PUT) && act.cell_we;

   // Scroll pass: the cell one row below feeds the cell being written
   assign sweep_raddr    = AW'((AW+1)'(cnt_ff) + (AW+1)'(SCREEN_COLS));
   assign sweep_last_row = (cnt_ff >= LAST_ROW_BASE);

   assign idx_in_range = (CMP_W'(item_idx_ff) < CMP_W'(CELL_COUNT));

   // Reset fill uses the fixed attribute; clears and scrolled-in blank rows use the register value
   assign fill_attr = (kind_ff == SW_INIT) ? RESET_ATTR : default_attr_ff;

   // ------------------------------------------------------------------
   // Sequencer: next state and datapath controls
   // ------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      cnt_in         = cnt_ff;
      scroll_left_in = scroll_left_ff;
      cur_row_in     = cur_row_ff;
      cur_col_in     = cur_col_ff;
      wpend_in       = 1'b0;
      waddr_in       = cnt_ff;
      wblank_in      = 1'b1;
      mem_re         = 1'b0;
      mem_raddr      = sweep_raddr;
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_if.valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (item_cmd_ff == CMD_READ) begin
               mem_re    = idx_in_range;
               mem_raddr = AW'(item_idx_ff);
               state_in  = ST_DONE;
            end else begin
               cur_row_in = step_row;
               cur_col_in = step_col;
               if (act.clear) begin
                  kind_in  = SW_CLEAR;
                  state_in = ST_SWEEP;
               end else if (act.scroll_cnt != '0) begin
                  kind_in        = SW_SCROLL;
                  scroll_left_in = act.scroll_cnt;
                  state_in       = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            // issue the read now, write the cell in the next cycle
            mem_re    = (kind_ff == SW_SCROLL) && !sweep_last_row;
            wpend_in  = 1'b1;
            waddr_in  = cnt_ff;
            wblank_in = (kind_ff != SW_SCROLL) || sweep_last_row;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            if ((kind_ff == SW_SCROLL) && (scroll_left_ff > SCROLL_CNT_W'(1))) begin
               scroll_left_in = scroll_left_ff - SCROLL_CNT_W'(1);
               state_in       = ST_SWEEP;
            end else if (kind_ff == SW_INIT) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_if.ready = req_ready;

   // ------------------------------------------------------------------
   // Cell store ports: the sweep write stage and a put write never meet
   // ------------------------------------------------------------------
   always_comb begin
      mem_we = wpend_ff || put_we;
      if (wpend_ff) begin
         mem_waddr = waddr_ff;
         mem_wdata = wblank_ff ? {fill_attr, CH_BLANK} : rd_data_ff;
      end else begin
         mem_waddr = put_addr;
         mem_wdata = {item_attr_ff, step_wr_char};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= cell_mem[mem_raddr];
      end
   end

   // ------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[CSR_ADDR_W-1:2] == REG_DEFAULT_ATTR);
   assign default_attr_in = csr_write ? csr_pwdata[ATTR_W-1:0] : default_attr_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr[CSR_ADDR_W-1:2] == REG_DEFAULT_ATTR) ?
                            CSR_DATA_W'(default_attr_ff) : '0;

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_row_ff <= ROW_OUT_W'(cur_row_ff);
         rsp_col_ff <= COL_OUT_W'(cur_col_ff);
         rsp_pos_ff <= POS_OUT_W'(AW'(cur_row_ff) * AW'(SCREEN_COLS) + AW'(cur_col_ff));
         if ((item_cmd_ff == CMD_READ) && idx_in_range) begin
            rsp_char_ff <= rd_data_ff[CHAR_W-1:0];
            rsp_attr_ff <= rd_data_ff[CELL_W-1:CHAR_W];
         end else begin
            rsp_char_ff <= '0;
            rsp_attr_ff <= '0;
         end
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_row = rsp_row_ff;
   assign rsp_if.cursor_col = rsp_col_ff;
   assign rsp_if.cursor_pos = rsp_pos_ff;
   assign rsp_if.read_char  = rsp_char_ff;
   assign rsp_if.read_attr  = rsp_attr_ff;

   // ------------------------------------------------------------------
   // Request capture
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_ready && req_if.valid) begin
         item_cmd_ff  <= req_if.cmd;
         item_char_ff <= req_if.char_code;
         item_attr_ff <= req_if.cell_attr;
         item_idx_ff  <= req_if.cell_index;
      end
   end

   // ------------------------------------------------------------------
   // Control registers: reset starts the blank fill of the store
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SWEEP;
         kind_ff         <= SW_INIT;
         cnt_ff          <= '0;
         scroll_left_ff  <= '0;
         cur_row_ff      <= '0;
         cur_col_ff      <= '0;
         default_attr_ff <= RESET_ATTR;
         wpend_ff        <= 1'b0;
         waddr_ff        <= '0;
         wblank_ff       <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         kind_ff         <= kind_in;
         cnt_ff          <= cnt_in;
         scroll_left_ff  <= scroll_left_in;
         cur_row_ff      <= cur_row_in;
         cur_col_ff      <= cur_col_in;
         default_attr_ff <= default_attr_in;
         wpend_ff        <= wpend_in;
         waddr_ff        <= waddr_in;
         wblank_ff       <= wblank_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_cursor_in_screen: assert property (@(posedge clock) disable iff (reset)
      (cur_row_ff <= RW'(SCREEN_ROWS - 1)) && (cur_col_ff <= CW'(SCREEN_COLS - 1)))
      else $error("cursor left the screen");

   a_write_ports_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(wpend_ff && put_we))
      else $error("sweep write collided with a put write");

   a_sweep_feeds_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |=> wpend_ff && (waddr_ff == $past(cnt_ff)))
      else $error("sweep write stage lost a cell");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_if.ready |=> (state_ff == ST_DONE))
      else $error("result overwrote a waiting response");

   a_form_feed_homes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && (item_cmd_ff == CMD_PUT) && (item_char_ff == CH_FF)
      |=> (cur_row_ff == '0) && (cur_col_ff == '0))
      else $error("form feed did not home the cursor");

endmodule

// ----- rtl/tcce_cursor.sv -----
// Put-code decoder: next cursor, cell write and scroll/clear requests.
// Depends on tcce_pkg; instantiated by text_console_character_engine.
module tcce_cursor import tcce_pkg::*; #(
   parameter int SCREEN_ROWS = DEF_SCREEN_ROWS,
   parameter int SCREEN_COLS = DEF_SCREEN_COLS,
   parameter int RW = $clog2(SCREEN_ROWS),
   parameter int CW = $clog2(SCREEN_COLS)
) (
   input  logic [RW-1:0]     cur_row,
   input  logic [CW-1:0]     cur_col,
   input  logic [CHAR_W-1:0] char_code,
   output tcce_act_type      act,
   output logic [RW-1:0]     wr_row,
   output logic [CW-1:0]     wr_col,
   output logic [CHAR_W-1:0] wr_char,
   output logic [RW-1:0]     next_row,
   output logic [CW-1:0]     next_col
);

   localparam logic [RW-1:0] LAST_ROW = RW'(SCREEN_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(SCREEN_COLS - 1);

   logic            printable;
   logic [RW-1:0]   adv_row;
   logic            adv_scroll;
   logic [CW:0]     tab_col;
   logic [RW+2:0]   vt_row;

   assign printable = ((char_code > CH_LAST_CTRL) && (char_code != CH_DEL)) ||
                      (char_code == CH_NAK);

   // Step to the next row, or scroll once when already on the last one
   assign adv_scroll = (cur_row == LAST_ROW);
   assign adv_row    = adv_scroll ? cur_row : cur_row + RW'(1);

   assign tab_col = ((CW+1)'(cur_col) & ~(CW+1)'(3)) + (CW+1)'(4);
   assign vt_row  = ((RW+3)'(cur_row) & ~(RW+3)'(3)) + (RW+3)'(4);

   always_comb begin
      act      = '0;
      wr_row   = cur_row;
      wr_col   = cur_col;
      wr_char  = char_code;
      next_row = cur_row;
      next_col = cur_col;
      if (printable) begin
         act.cell_we = 1'b1;
         if (cur_col == LAST_COL) begin
            next_col       = '0;
            next_row       = adv_row;
            act.scroll_cnt = SCROLL_CNT_W'(adv_scroll);
         end else begin
            next_col = cur_col + CW'(1);
         end
      end else begin
         unique case (char_code)
            CH_LF: begin
               next_col       = '0;
               next_row       = adv_row;
               act.scroll_cnt = SCROLL_CNT_W'(adv_scroll);
            end
            CH_CR: begin
               next_col = '0;
            end
            CH_BS: begin
               wr_char = CH_BLANK;
               if (cur_col != '0) begin
                  act.cell_we = 1'b1;
                  wr_col      = cur_col - CW'(1);
                  next_col    = cur_col - CW'(1);
               end else if (cur_row != '0) begin
                  // blank the last cell of the row above
                  act.cell_we = 1'b1;
                  wr_row      = cur_row - RW'(1);
                  wr_col      = LAST_COL;
                  next_row    = cur_row - RW'(1);
                  next_col    = LAST_COL;
               end else begin
                  next_col = LAST_COL;
               end
            end
            CH_TAB: begin
               if (tab_col >= (CW+1)'(SCREEN_COLS)) begin
                  next_col       = CW'(tab_col - (CW+1)'(SCREEN_COLS));
                  next_row       = adv_row;
                  act.scroll_cnt = SCROLL_CNT_W'(adv_scroll);
               end else begin
                  next_col = CW'(tab_col);
               end
            end
            CH_VT: begin
               if (vt_row >= (RW+3)'(SCREEN_ROWS)) begin
                  next_row       = LAST_ROW;
                  act.scroll_cnt = SCROLL_CNT_W'(vt_row - (RW+3)'(SCREEN_ROWS - 1));
               end else begin
                  next_row = RW'(vt_row);
               end
            end
            CH_FF: begin
               act.clear = 1'b1;
               next_row  = '0;
               next_col  = '0;
            end
            default: begin
            end
         endcase
      end
   end

endmodule
